>>> hdl/nfb_pkg.sv
// ----------------------------------------------------------------------------
// nfb_pkg
// Shared types, register indexes, event codes and digit helpers for the
// nixie frame builder.
// ----------------------------------------------------------------------------
package nfb_pkg;

  localparam int unsigned FrameW    = 64;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned HourW     = 5;
  localparam int unsigned MinuteW   = 6;
  localparam int unsigned SecondW   = 6;
  localparam int unsigned ValW      = 7;   // widest value shown on a tube pair (99)
  localparam int unsigned DigitW    = 4;
  localparam int unsigned StepsW    = 12;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned FifoDepth = 4;

  // event codes
  localparam logic [ModeW-1:0] ModeSecond   = 3'd0;
  localparam logic [ModeW-1:0] ModeHour     = 3'd1;
  localparam logic [ModeW-1:0] ModeRefresh  = 3'd2;
  localparam logic [ModeW-1:0] ModeSyncGain = 3'd3;
  localparam logic [ModeW-1:0] ModeSyncLost = 3'd4;
  localparam logic [ModeW-1:0] ModeClean    = 3'd5;

  // register indexes
  localparam logic [CfgIndexW-1:0] RegDisplayOn     = 3'd0;
  localparam logic [CfgIndexW-1:0] RegMode24h       = 3'd1;
  localparam logic [CfgIndexW-1:0] RegDotBlink      = 3'd2;
  localparam logic [CfgIndexW-1:0] RegCleaningSteps = 3'd3;
  localparam logic [CfgIndexW-1:0] RegCleaningHour  = 3'd4;

  localparam logic [StepsW-1:0] StepsReset    = 12'd3000;
  localparam logic [HourW-1:0]  CleanHourReset = 5'd4;
  localparam logic [DigitW-1:0] LastDigit     = 4'd9;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } in_t;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic              last;
  } out_t;

  typedef struct packed {
    logic              display_on;
    logic              mode_24h;
    logic              dot_blink;
    logic [StepsW-1:0] cleaning_steps;
    logic [HourW-1:0]  cleaning_hour;
  } cfg_t;

  // tens digit of a value below 100: multiply by reciprocal 205/2048
  function automatic logic [DigitW-1:0] tens(input logic [ValW-1:0] v);
    logic [ValW+8-1:0] p;
    p = (ValW+8)'(v) * (ValW+8)'(205);
    return p[DigitW+11-1:11];
  endfunction

  function automatic logic [DigitW-1:0] ones(input logic [ValW-1:0] v);
    logic [ValW-1:0] t;
    t = ValW'(tens(v));
    return DigitW'(v - ValW'(t * ValW'(10)));
  endfunction

  function automatic logic [9:0] onehot10(input logic [DigitW-1:0] d);
    return 10'(1) << d;
  endfunction

endpackage

>>> hdl/nixie_frame_builder_with_cleaning.sv
// ----------------------------------------------------------------------------
// nixie_frame_builder_with_cleaning
// Turns clock events into nixie shift frames, with cathode cleaning.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one clock event per transaction (mode plus current time).
//   out_*  : shift frames, bit 63 shifted first; last marks the final
//            frame of an event. A cleaning tick that ends cleaning gives
//            a cleaning frame followed by the time frame.
//   cfg_*  : register writes (index, data); always ready. Write only while
//            no event is pending.
//   Events: an event is registered on accept and processed once the
//   result queue has room for two frames; its frames reach out_* via the queue.
//   Throughput: one event per cycle while the receiver keeps up; the
//   output port gives one frame per cycle while out_ready_i is high. A
//   four-entry result queue sets how far the input side runs ahead of a
//   stalled receiver; when fewer than two entries are free the pending
//   event waits and in_ready_o drops.
//   Reset: registers take their reset values, sync and cleaning are
//   cleared, the queue empties.
// ----------------------------------------------------------------------------
module nixie_frame_builder_with_cleaning (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  nfb_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output nfb_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nfb_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [nfb_pkg::CfgDataW-1:0]       cfg_data_i
);

  nfb_pkg::cfg_t cfg_q;
  nfb_pkg::in_t  in_q;
  logic          in_vld_q;
  logic          space2, proc;

  logic                        synced_q, synced_d;
  logic                        cleaning_q, cleaning_d;
  logic [nfb_pkg::DigitW-1:0]  digit_q, digit_d;
  logic [nfb_pkg::StepsW-1:0]  count_q, count_d, count_inc;

  logic [nfb_pkg::HourW-1:0]   hour12;
  logic [nfb_pkg::HourW-1:0]   hour_disp;
  logic [nfb_pkg::ValW-1:0]    clean_val;
  logic [nfb_pkg::FrameW-1:0]  time_frame, clean_frame;

  logic          push0, push1;
  nfb_pkg::out_t data0, data1;

  assign cfg_ready_o = 1'b1;
  assign proc        = in_vld_q & space2;
  assign in_ready_o  = ~in_vld_q | proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_on     <= 1'b1;
      cfg_q.mode_24h       <= 1'b0;
      cfg_q.dot_blink      <= 1'b1;
      cfg_q.cleaning_steps <= nfb_pkg::StepsReset;
      cfg_q.cleaning_hour  <= nfb_pkg::CleanHourReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nfb_pkg::RegDisplayOn:     cfg_q.display_on     <= cfg_data_i[0];
        nfb_pkg::RegMode24h:       cfg_q.mode_24h       <= cfg_data_i[0];
        nfb_pkg::RegDotBlink:      cfg_q.dot_blink      <= cfg_data_i[0];
        nfb_pkg::RegCleaningSteps: cfg_q.cleaning_steps <= cfg_data_i[nfb_pkg::StepsW-1:0];
        nfb_pkg::RegCleaningHour:  cfg_q.cleaning_hour  <= cfg_data_i[nfb_pkg::HourW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      synced_q   <= 1'b0;
      cleaning_q <= 1'b0;
      digit_q    <= '0;
      count_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      synced_q   <= synced_d;
      cleaning_q <= cleaning_d;
      digit_q    <= digit_d;
      count_q    <= count_d;
    end
  end

  // 12-hour display
  always_comb begin
    hour12 = in_q.hour - nfb_pkg::HourW'(12);
    if (hour12 == '0) begin
      hour12 = nfb_pkg::HourW'(12);
    end
    if (!cfg_q.mode_24h && (in_q.hour >= nfb_pkg::HourW'(12))) begin
      hour_disp = hour12;
    end else begin
      hour_disp = in_q.hour;
    end
  end

  assign clean_val = nfb_pkg::ValW'(digit_q) * nfb_pkg::ValW'(11);

  nfb_frame u_time_frame (
    .cfg_i    (cfg_q),
    .hour_i   (nfb_pkg::ValW'(hour_disp)),
    .minute_i (nfb_pkg::ValW'(in_q.minute)),
    .second_i (nfb_pkg::ValW'(in_q.second)),
    .frame_o  (time_frame)
  );

  nfb_frame u_clean_frame (
    .cfg_i    (cfg_q),
    .hour_i   (clean_val),
    .minute_i (clean_val),
    .second_i (clean_val),
    .frame_o  (clean_frame)
  );

  assign count_inc = count_q + nfb_pkg::StepsW'(1);

  always_comb begin
    synced_d   = synced_q;
    cleaning_d = cleaning_q;
    digit_d    = digit_q;
    count_d    = count_q;
    push0      = 1'b0;
    push1      = 1'b0;
    data0      = '{frame: time_frame, last: 1'b1};
    data1      = '{frame: time_frame, last: 1'b1};
    if (proc) begin
      case (in_q.mode)
        nfb_pkg::ModeSecond, nfb_pkg::ModeRefresh: begin
          push0 = synced_q & ~cleaning_q;
        end
        nfb_pkg::ModeHour: begin
          if ((in_q.hour == cfg_q.cleaning_hour) && (in_q.minute == '0)) begin
            cleaning_d = 1'b1;
            digit_d    = '0;
            count_d    = '0;
          end
        end
        nfb_pkg::ModeSyncGain: begin
          synced_d = 1'b1;
          push0    = 1'b1;
        end
        nfb_pkg::ModeSyncLost: begin
          synced_d = 1'b0;
        end
        nfb_pkg::ModeClean: begin
          if (synced_q && cleaning_q) begin
            push0       = 1'b1;
            data0.frame = clean_frame;
            digit_d     = (digit_q == nfb_pkg::LastDigit) ? '0
                                                          : digit_q + nfb_pkg::DigitW'(1);
            if (count_inc >= cfg_q.cleaning_steps) begin
              cleaning_d = 1'b0;
              count_d    = '0;
              data0.last = 1'b0;
              push1      = 1'b1;
            end else begin
              count_d = count_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  nfb_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (push0),
    .push1_i     (push1),
    .data0_i     (data0),
    .data1_i     (data1),
    .space2_o    (space2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/nfb_frame.sv
// ----------------------------------------------------------------------------
// nfb_frame
// Builds one 64-bit shift frame from hour, minute and second values.
// ----------------------------------------------------------------------------
module nfb_frame (
  input  nfb_pkg::cfg_t                 cfg_i,
  input  logic [nfb_pkg::ValW-1:0]      hour_i,
  input  logic [nfb_pkg::ValW-1:0]      minute_i,
  input  logic [nfb_pkg::ValW-1:0]      second_i,
  output logic [nfb_pkg::FrameW-1:0]    frame_o
);

  logic [3:0] dots;

  assign dots = {4{second_i[0] & cfg_i.dot_blink}};

  always_comb begin
    if (cfg_i.display_on) begin
      frame_o = {dots,
                 nfb_pkg::onehot10(nfb_pkg::ones(second_i)),
                 nfb_pkg::onehot10(nfb_pkg::tens(second_i)),
                 nfb_pkg::onehot10(nfb_pkg::ones(minute_i)),
                 nfb_pkg::onehot10(nfb_pkg::tens(minute_i)),
                 nfb_pkg::onehot10(nfb_pkg::ones(hour_i)),
                 nfb_pkg::onehot10(nfb_pkg::tens(hour_i))};
    end else begin
      frame_o = '0;
    end
  end

endmodule

>>> hdl/nfb_result_fifo.sv
// ----------------------------------------------------------------------------
// nfb_result_fifo
// Small result queue; takes up to two frames per cycle, gives one while out_ready_i is high.
// ----------------------------------------------------------------------------
module nfb_result_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push0_i,
  input  logic           push1_i,
  input  nfb_pkg::out_t  data0_i,
  input  nfb_pkg::out_t  data1_i,
  output logic           space2_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nfb_pkg::out_t  out_data_o
);

  localparam int unsigned PtrW = $clog2(nfb_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(nfb_pkg::FifoDepth + 1);

  nfb_pkg::out_t   mem_q [nfb_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [CntW-1:0] n_push;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign space2_o    = (cnt_q <= CntW'(nfb_pkg::FifoDepth - 2));
  assign n_push      = CntW'(push0_i) + CntW'(push1_i);
  assign wr_ptr_d    = wr_ptr_q + PtrW'(n_push);
  assign rd_ptr_d    = rd_ptr_q + PtrW'(pop);
  assign cnt_d       = cnt_q + n_push - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> bench/tb_nixie_frame_builder_with_cleaning.sv
// ----------------------------------------------------------------------------
// tb_nixie_frame_builder_with_cleaning
// Self-checking bench for the nixie frame builder. A short table of directed
// clock events is followed by random event streams under several register
// settings. Both handshakes idle at random. Each accepted frame is compared
// against a cycle-free model of the display, sync and cleaning behavior.
// ----------------------------------------------------------------------------
module tb_nixie_frame_builder_with_cleaning;

  localparam int ResetCycles  = 10;
  localparam int SettleCycles = 4;
  localparam int DrainCycles  = 8;
  localparam int StuckLimit   = 2000;
  localparam int RandPhases   = 7;
  localparam int PhaseItems   = 100;
  localparam int TubeBase     = 4;
  localparam int TubeSpan     = 10;

  localparam logic [nfb_pkg::ModeW-1:0]     ModeUndefLo = 3'd6;
  localparam logic [nfb_pkg::ModeW-1:0]     ModeUndefHi = 3'd7;
  localparam logic [nfb_pkg::CfgIndexW-1:0] RegSpareLo  = 3'd5;
  localparam logic [nfb_pkg::CfgIndexW-1:0] RegSpareHi  = 3'd7;

  localparam logic [nfb_pkg::FrameW-1:0] AllZeroDigits = 64'h0004_0100_4010_0401;

  typedef struct packed {
    nfb_pkg::in_t               ev;
    logic                       typed;
    logic [nfb_pkg::FrameW-1:0] frame;
  } row_t;

  localparam int NumRows = 23;
  localparam row_t DirRows [0:NumRows-1] = '{
    '{'{nfb_pkg::ModeSecond,   5'd12, 6'd34, 6'd56}, 1'b0, '0},
    '{'{nfb_pkg::ModeSyncLost, 5'd0,  6'd0,  6'd0 }, 1'b0, '0},
    '{'{ModeUndefLo,           5'd1,  6'd2,  6'd3 }, 1'b0, '0},
    '{'{ModeUndefHi,           5'd31, 6'd63, 6'd63}, 1'b0, '0},
    '{'{nfb_pkg::ModeSyncGain, 5'd0,  6'd0,  6'd0 }, 1'b1, AllZeroDigits},
    '{'{nfb_pkg::ModeSecond,   5'd23, 6'd59, 6'd59}, 1'b0, '0},
    '{'{nfb_pkg::ModeRefresh,  5'd12, 6'd0,  6'd1 }, 1'b0, '0},
    '{'{nfb_pkg::ModeSecond,   5'd13, 6'd7,  6'd60}, 1'b0, '0},
    '{'{nfb_pkg::ModeRefresh,  5'd31, 6'd63, 6'd63}, 1'b0, '0},
    '{'{nfb_pkg::ModeHour,     5'd4,  6'd1,  6'd0 }, 1'b0, '0},
    '{'{nfb_pkg::ModeHour,     5'd5,  6'd0,  6'd0 }, 1'b0, '0},
    '{'{nfb_pkg::ModeClean,    5'd4,  6'd0,  6'd0 }, 1'b0, '0},
    '{'{nfb_pkg::ModeHour,     5'd4,  6'd0,  6'd0 }, 1'b0, '0},
    '{'{nfb_pkg::ModeSecond,   5'd4,  6'd0,  6'd1 }, 1'b0, '0},
    '{'{nfb_pkg::ModeClean,    5'd4,  6'd0,  6'd2 }, 1'b1, AllZeroDigits},
    '{'{nfb_pkg::ModeClean,    5'd4,  6'd0,  6'd3 }, 1'b0, '0},
    '{'{nfb_pkg::ModeSyncLost, 5'd4,  6'd0,  6'd4 }, 1'b0, '0},
    '{'{nfb_pkg::ModeClean,    5'd4,  6'd0,  6'd4 }, 1'b0, '0},
    '{'{nfb_pkg::ModeSyncGain, 5'd4,  6'd0,  6'd5 }, 1'b0, '0},
    '{'{nfb_pkg::ModeClean,    5'd4,  6'd0,  6'd6 }, 1'b0, '0},
    '{'{nfb_pkg::ModeHour,     5'd4,  6'd0,  6'd0 }, 1'b0, '0},
    '{'{nfb_pkg::ModeClean,    5'd4,  6'd0,  6'd7 }, 1'b1, AllZeroDigits},
    '{'{nfb_pkg::ModeRefresh,  5'd0,  6'd0,  6'd0 }, 1'b0, '0}
  };

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  nfb_pkg::in_t                  in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  nfb_pkg::out_t                 out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [nfb_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [nfb_pkg::CfgDataW-1:0]  cfg_data  = '0;

  nfb_pkg::cfg_t              cfg_shadow;
  logic                       is_synced;
  logic                       in_cleaning;
  logic [nfb_pkg::DigitW-1:0] clean_digit;
  logic [nfb_pkg::StepsW-1:0] clean_count;

  nfb_pkg::out_t pending_frames[$];
  int   mismatches   = 0;
  int   stuck_cycles = 0;
  bit   send_calm    = 1'b0;
  bit   recv_calm    = 1'b0;

  nixie_frame_builder_with_cleaning uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [nfb_pkg::FrameW-1:0] tube_pattern(input int unsigned h, m, s);
    logic [nfb_pkg::FrameW-1:0] f;
    int unsigned                dig[6];
    f = '0;
    if (!cfg_shadow.display_on) return '0;
    if ((s % 2) == 1 && cfg_shadow.dot_blink) f[63:60] = 4'hF;
    dig = '{s % 10, (s / 10) % 10, m % 10, (m / 10) % 10, h % 10, (h / 10) % 10};
    for (int i = 0; i < 6; i++) begin
      f[63 - (TubeBase + TubeSpan * i + 9 - dig[i])] = 1'b1;
    end
    return f;
  endfunction

  function automatic logic [nfb_pkg::FrameW-1:0] clock_frame(input int unsigned h, m, s);
    int unsigned hh;
    hh = h;
    if (!cfg_shadow.mode_24h && hh >= 12) begin
      hh -= 12;
      if (hh == 0) hh = 12;
    end
    return tube_pattern(hh, m, s);
  endfunction

  task automatic predict_frames(input nfb_pkg::in_t ev, output int n,
                                output nfb_pkg::out_t r0, output nfb_pkg::out_t r1);
    int unsigned v;
    n  = 0;
    r0 = '0;
    r1 = '0;
    case (ev.mode)
      nfb_pkg::ModeSecond, nfb_pkg::ModeRefresh: begin
        if (is_synced && !in_cleaning) begin
          r0.frame = clock_frame(ev.hour, ev.minute, ev.second);
          r0.last  = 1'b1;
          n = 1;
        end
      end
      nfb_pkg::ModeHour: begin
        if (ev.hour == cfg_shadow.cleaning_hour && ev.minute == 0) begin
          in_cleaning = 1'b1;
          clean_digit = '0;
          clean_count = '0;
        end
      end
      nfb_pkg::ModeSyncGain: begin
        is_synced = 1'b1;
        r0.frame  = clock_frame(ev.hour, ev.minute, ev.second);
        r0.last   = 1'b1;
        n = 1;
      end
      nfb_pkg::ModeSyncLost: is_synced = 1'b0;
      nfb_pkg::ModeClean: begin
        if (is_synced && in_cleaning) begin
          v = clean_digit * 11;
          r0.frame = tube_pattern(v, v, v);
          r0.last  = 1'b1;
          n = 1;
          clean_digit = (clean_digit == nfb_pkg::LastDigit) ? '0 : clean_digit + 1'b1;
          clean_count = clean_count + 1'b1;
          if (clean_count >= cfg_shadow.cleaning_steps) begin
            in_cleaning = 1'b0;
            clean_count = '0;
            r0.last  = 1'b0;
            r1.frame = clock_frame(ev.hour, ev.minute, ev.second);
            r1.last  = 1'b1;
            n = 2;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_event(input nfb_pkg::in_t ev, input logic typed,
                            input logic [nfb_pkg::FrameW-1:0] lit);
    int            gap;
    int            n;
    nfb_pkg::out_t r0;
    nfb_pkg::out_t r1;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    predict_frames(ev, n, r0, r1);
    if (typed) r0.frame = lit;
    if (n > 0) pending_frames.push_back(r0);
    if (n > 1) pending_frames.push_back(r1);
  endtask

  task automatic wait_drained();
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [nfb_pkg::CfgIndexW-1:0] idx,
                           input logic [nfb_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nfb_pkg::RegDisplayOn:     cfg_shadow.display_on     = val[0];
      nfb_pkg::RegMode24h:       cfg_shadow.mode_24h       = val[0];
      nfb_pkg::RegDotBlink:      cfg_shadow.dot_blink      = val[0];
      nfb_pkg::RegCleaningSteps: cfg_shadow.cleaning_steps = val[nfb_pkg::StepsW-1:0];
      nfb_pkg::RegCleaningHour:  cfg_shadow.cleaning_hour  = val[nfb_pkg::HourW-1:0];
      default: ;
    endcase
  endtask

  // upper data bits are don't-care; junk exercises that and writes a spare register index
  task automatic program_regs(input logic d, m, b, input logic [nfb_pkg::StepsW-1:0] steps,
                              input logic [nfb_pkg::HourW-1:0] hr, input bit junk);
    logic [nfb_pkg::CfgDataW-1:0] noise;
    noise = junk ? nfb_pkg::CfgDataW'($urandom) : '0;
    in_valid <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    write_reg(nfb_pkg::RegDisplayOn,     {noise[nfb_pkg::CfgDataW-1:1], d});
    write_reg(nfb_pkg::RegMode24h,       {noise[nfb_pkg::CfgDataW-1:1], m});
    write_reg(nfb_pkg::RegDotBlink,      {noise[nfb_pkg::CfgDataW-1:1], b});
    write_reg(nfb_pkg::RegCleaningSteps, nfb_pkg::CfgDataW'(steps));
    write_reg(nfb_pkg::RegCleaningHour,
              {noise[nfb_pkg::CfgDataW-1:nfb_pkg::HourW], hr});
    if (junk) write_reg(nfb_pkg::CfgIndexW'($urandom_range(RegSpareLo, RegSpareHi)),
                        nfb_pkg::CfgDataW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic nfb_pkg::in_t random_event();
    nfb_pkg::in_t ev;
    int           pick;
    ev.hour   = nfb_pkg::HourW'($urandom_range(0, 23));
    ev.minute = nfb_pkg::MinuteW'($urandom_range(0, 59));
    ev.second = nfb_pkg::SecondW'($urandom_range(0, 60));
    if ($urandom_range(0, 99) < 8) {ev.hour, ev.minute, ev.second} = 17'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25)      ev.mode = nfb_pkg::ModeSecond;
    else if (pick < 35) ev.mode = nfb_pkg::ModeRefresh;
    else if (pick < 65) ev.mode = nfb_pkg::ModeClean;
    else if (pick < 75) begin
      ev.mode = nfb_pkg::ModeHour;
      if ($urandom_range(0, 9) < 7) begin
        ev.hour   = cfg_shadow.cleaning_hour;
        ev.minute = '0;
      end
    end
    else if (pick < 85) ev.mode = nfb_pkg::ModeSyncGain;
    else if (pick < 90) ev.mode = nfb_pkg::ModeSyncLost;
    else if (pick < 94) ev.mode = nfb_pkg::ModeW'($urandom_range(ModeUndefLo, ModeUndefHi));
    else                ev.mode = nfb_pkg::ModeSecond;
    return ev;
  endfunction

  initial begin : stimulus
    cfg_shadow = '{display_on: 1'b1, mode_24h: 1'b0, dot_blink: 1'b1,
                   cleaning_steps: nfb_pkg::StepsReset,
                   cleaning_hour: nfb_pkg::CleanHourReset};
    is_synced   = 1'b0;
    in_cleaning = 1'b0;
    clean_digit = '0;
    clean_count = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      send_event(DirRows[i].ev, DirRows[i].typed, DirRows[i].frame);
    end

    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0:       program_regs(1'b1, 1'b1, 1'b1, 12'd1,    5'd0,  1'b0);
        1:       program_regs(1'b0, 1'b0, 1'b0, 12'd4095, 5'd23, 1'b0);
        2:       program_regs(1'b1, 1'b0, 1'b1, 12'd0,    5'd31, 1'b1);
        default: program_regs($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)),
                              nfb_pkg::StepsW'($urandom_range(1, 30)),
                              nfb_pkg::HourW'($urandom_range(0, 23)), 1'b1);
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
        if (k == PhaseItems / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_event(random_event(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    int served;
    served = 0;
    wait (rst_n);
    forever begin
      if (served % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  always @(posedge clk) begin : frame_check
    nfb_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual frame %h last %b",
                 $time, out_data.frame, out_data.last);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        if (out_data.frame !== want.frame) begin
          $display("%0t: frame mismatch, expected %h actual %h", $time, want.frame,
                   out_data.frame);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $time, want.last,
                   out_data.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == StuckLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
